// ===== rtl/core/hsl_to_rgb_converter_macros.svh =====
// ----------------------------------------------------------------------------
// HSL to RGB converter assertion macros
// Concurrent check wrappers, empty in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef HSL_TO_RGB_CONVERTER_MACROS_SVH
`define HSL_TO_RGB_CONVERTER_MACROS_SVH

`ifndef SYNTHESIS

// Consequent holds in the same cycle as the antecedent.
`define HSL2RGB_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("hsl_to_rgb_converter check failed");

// Consequent holds in the cycle after the antecedent.
`define HSL2RGB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("hsl_to_rgb_converter check failed");

`else

`define HSL2RGB_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define HSL2RGB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/core/hsl2rgb_pkg.sv =====
// ----------------------------------------------------------------------------
// HSL to RGB converter package
// Shared widths, constants and pipeline control type.
// ----------------------------------------------------------------------------
package hsl2rgb_pkg;

	parameter int HUE_BITS_DEF = 12;
	parameter int CH_W         = 8;
	parameter int SCALED_W     = 16;

	parameter logic [CH_W-1:0] CH_FULL = 8'd255;

	typedef struct packed {
		logic load_s1;
		logic load_s2;
		logic load_s3;
	} hsl2rgb_ctl_t;

endpackage

// ===== rtl/core/hsl2rgb_chan.sv =====
// ----------------------------------------------------------------------------
// HSL to RGB channel datapath
// Hue ramp weight, ramp product and divide-by-255 for one color channel.
// ----------------------------------------------------------------------------
module hsl2rgb_chan #(
	parameter int HUE_BITS = hsl2rgb_pkg::HUE_BITS_DEF
) (
	input  logic                                clk,
	input  hsl2rgb_pkg::hsl2rgb_ctl_t           ctl,
	input  logic [HUE_BITS+1:0]                 tn,
	input  logic [hsl2rgb_pkg::SCALED_W-1:0]    d_s1,
	input  logic [hsl2rgb_pkg::SCALED_W-1:0]    pv_s2,
	output logic [hsl2rgb_pkg::CH_W-1:0]        ch_s3
);
	import hsl2rgb_pkg::*;

	localparam int W_W    = HUE_BITS + 1;
	localparam int T2_W   = HUE_BITS + 3;
	localparam int PROD_W = SCALED_W + W_W;
	localparam int Y_W    = SCALED_W + 1;

	localparam logic [T2_W-1:0]   TURN1 = {3'b001, {HUE_BITS{1'b0}}};
	localparam logic [T2_W-1:0]   TURN3 = {3'b011, {HUE_BITS{1'b0}}};
	localparam logic [T2_W-1:0]   TURN4 = {3'b100, {HUE_BITS{1'b0}}};
	localparam logic [HUE_BITS+1:0] TN_TWO = {2'b10, {HUE_BITS{1'b0}}};
	localparam logic [W_W-1:0]    W_FULL = {1'b1, {HUE_BITS{1'b0}}};

	logic [T2_W-1:0]   tn2;
	logic [T2_W-1:0]   fall;
	logic [W_W-1:0]    w;
	logic [W_W-1:0]    w_s1;
	logic [PROD_W-1:0] prod_s2;
	logic [Y_W-1:0]    y;
	logic [CH_W:0]     q0;
	logic [CH_W+1:0]   rem;
	logic [CH_W:0]     quo;
	logic [CH_W-1:0]   ch;

	assign tn2  = {tn, 1'b0};
	assign fall = TURN4 - tn2;

	always_comb begin
		priority if (tn2 < TURN1) begin
			w = tn2[W_W-1:0];
		end else if (tn2 < TURN3) begin
			w = W_FULL;
		end else if (tn < TN_TWO) begin
			w = fall[W_W-1:0];
		end else begin
			w = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_s1) begin
			w_s1 <= w;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_s2) begin
			prod_s2 <= PROD_W'(d_s1) * PROD_W'(w_s1);
		end
	end

	assign y   = Y_W'(pv_s2) + prod_s2[HUE_BITS+Y_W-1:HUE_BITS];
	assign q0  = y[Y_W-1:CH_W];
	assign rem = (CH_W+2)'(y[CH_W-1:0]) + (CH_W+2)'(q0);
	assign quo = q0 + (CH_W+1)'(rem >= (CH_W+2)'(CH_FULL));
	assign ch  = quo[CH_W] ? CH_FULL : quo[CH_W-1:0];

	always_ff @(posedge clk) begin
		if (ctl.load_s3) begin
			ch_s3 <= ch;
		end
	end

endmodule

// ===== rtl/core/hsl_to_rgb_converter.sv =====
// ----------------------------------------------------------------------------
// HSL to RGB converter
// Streams HSL-plus-alpha pixels to 8-bit RGBA with exact truncating math.
// ----------------------------------------------------------------------------
// Takes one pixel per clock while s_tready is high: the work is
// split over three register stages (q/p and hue offsets, ramp multiply,
// divide by 255), each with its own valid bit, so a stalled output only
// holds the stages that are full. Zero saturation yields gray equal to
// lightness, alpha passes through, and only the low HUE_BITS of hue count.
`include "hsl_to_rgb_converter_macros.svh"

module hsl_to_rgb_converter #(
	parameter int HUE_BITS = hsl2rgb_pkg::HUE_BITS_DEF,
	localparam int IN_W    = ((HUE_BITS + 3 * hsl2rgb_pkg::CH_W + 7) / 8) * 8,
	localparam int OUT_W   = 4 * hsl2rgb_pkg::CH_W
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,   // hue, saturation, lightness, alpha_in
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata    // red, green, blue, alpha_out
);
	import hsl2rgb_pkg::*;

	localparam int TN_W = HUE_BITS + 2;

	localparam logic [TN_W:0] TURN1 = {3'b001, {HUE_BITS{1'b0}}};
	localparam logic [TN_W:0] TURN2 = {3'b010, {HUE_BITS{1'b0}}};
	localparam logic [TN_W:0] TURN3 = {3'b011, {HUE_BITS{1'b0}}};

	logic [HUE_BITS-1:0] hue;
	logic [CH_W-1:0]     saturation;
	logic [CH_W-1:0]     lightness;
	logic [CH_W-1:0]     alpha_in;

	logic                rdy1, rdy2, rdy3;
	logic                v_s1, v_s2, v_s3;
	hsl2rgb_ctl_t        ctl;

	logic [SCALED_W-1:0] ls_prod;
	logic [SCALED_W:0]   l255;
	logic [SCALED_W:0]   s255;
	logic [SCALED_W:0]   q;
	logic [SCALED_W:0]   p;
	logic [SCALED_W:0]   d;
	logic [TN_W-1:0]     base;
	logic [TN_W:0]       sum_r, sum_b;
	logic [TN_W:0]       wrap_r, wrap_b;
	logic [TN_W-1:0]     tn_r, tn_g, tn_b;

	logic [SCALED_W-1:0] pv_s1, d_s1, pv_s2;
	logic [CH_W-1:0]     a_s1, a_s2, a_s3;
	logic [CH_W-1:0]     red_s3, green_s3, blue_s3;

	assign hue        = s_tdata[HUE_BITS-1:0];
	assign saturation = s_tdata[HUE_BITS+CH_W-1:HUE_BITS];
	assign lightness  = s_tdata[HUE_BITS+2*CH_W-1:HUE_BITS+CH_W];
	assign alpha_in   = s_tdata[HUE_BITS+3*CH_W-1:HUE_BITS+2*CH_W];

	assign rdy3     = !v_s3 || m_tready;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign s_tready = rdy1;

	assign ctl.load_s1 = s_tvalid && rdy1;
	assign ctl.load_s2 = v_s1 && rdy2;
	assign ctl.load_s3 = v_s2 && rdy3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy1) begin
				v_s1 <= s_tvalid;
			end
			if (rdy2) begin
				v_s2 <= v_s1;
			end
			if (rdy3) begin
				v_s3 <= v_s2;
			end
		end
	end

	assign ls_prod = SCALED_W'(lightness) * SCALED_W'(saturation);
	assign l255    = {1'b0, lightness, {CH_W{1'b0}}} - (SCALED_W+1)'(lightness);
	assign s255    = {1'b0, saturation, {CH_W{1'b0}}} - (SCALED_W+1)'(saturation);

	always_comb begin
		if (lightness[CH_W-1]) begin
			q = l255 + s255 - (SCALED_W+1)'(ls_prod);
		end else begin
			q = l255 + (SCALED_W+1)'(ls_prod);
		end
	end

	assign p = {l255[SCALED_W-1:0], 1'b0} - q;
	assign d = q - p;

	assign base   = {1'b0, hue, 1'b0} + {2'b00, hue};
	assign sum_r  = {1'b0, base} + TURN1;
	assign sum_b  = {1'b0, base} + TURN2;
	assign wrap_r = (sum_r >= TURN3) ? sum_r - TURN3 : sum_r;
	assign wrap_b = (sum_b >= TURN3) ? sum_b - TURN3 : sum_b;
	assign tn_r   = wrap_r[TN_W-1:0];
	assign tn_g   = base;
	assign tn_b   = wrap_b[TN_W-1:0];

	always_ff @(posedge clk) begin
		if (ctl.load_s1) begin
			pv_s1 <= p[SCALED_W-1:0];
			d_s1  <= d[SCALED_W-1:0];
			a_s1  <= alpha_in;
		end
		if (ctl.load_s2) begin
			pv_s2 <= pv_s1;
			a_s2  <= a_s1;
		end
		if (ctl.load_s3) begin
			a_s3 <= a_s2;
		end
	end

	hsl2rgb_chan #(
		.HUE_BITS (HUE_BITS)
	) u_red (
		.clk   (clk),
		.ctl   (ctl),
		.tn    (tn_r),
		.d_s1  (d_s1),
		.pv_s2 (pv_s2),
		.ch_s3 (red_s3)
	);

	hsl2rgb_chan #(
		.HUE_BITS (HUE_BITS)
	) u_green (
		.clk   (clk),
		.ctl   (ctl),
		.tn    (tn_g),
		.d_s1  (d_s1),
		.pv_s2 (pv_s2),
		.ch_s3 (green_s3)
	);

	hsl2rgb_chan #(
		.HUE_BITS (HUE_BITS)
	) u_blue (
		.clk   (clk),
		.ctl   (ctl),
		.tn    (tn_b),
		.d_s1  (d_s1),
		.pv_s2 (pv_s2),
		.ch_s3 (blue_s3)
	);

	assign m_tvalid = v_s3;
	assign m_tdata  = {a_s3, blue_s3, green_s3, red_s3};

	`HSL2RGB_ASSERT_NEXT(a_accept_fills_s1, clk, arst_n, s_tvalid && s_tready, v_s1)
	`HSL2RGB_ASSERT_NEXT(a_advance_fills_s2, clk, arst_n, ctl.load_s2, v_s2)
	`HSL2RGB_ASSERT_NOW(a_empty_out_ready, clk, arst_n, !v_s3, s_tready)
	`HSL2RGB_ASSERT_NEXT(a_drain_empties, clk, arst_n, m_tvalid && m_tready && !v_s2, !m_tvalid)

endmodule

// ===== test/tb_hsl_to_rgb_converter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSL to RGB converter testbench
// Streams directed and random HSL-plus-alpha pixels through the converter
// under random source gaps and sink stalls, plus one long sink hold-off that
// backs the pipeline up. Every output is compared field by field, in order,
// with a queued exact integer model of the hue ramp or a typed directed row.
// ----------------------------------------------------------------------------
module tb_hsl_to_rgb_converter;
	import hsl2rgb_pkg::*;

	localparam int  HB          = HUE_BITS_DEF;
	localparam int  IN_W        = ((HB + 3 * CH_W + 7) / 8) * 8;
	localparam int  OUT_W       = 4 * CH_W;
	localparam int  N_DIRECTED  = 22;
	localparam int  N_RANDOM    = 1680;
	localparam int  QUIET_TAIL  = 250;
	localparam int  HOLD_AT     = 300;
	localparam int  HOLD_CYCLES = 96;
	localparam int  DRAIN_CYCLES = 16;
	localparam int  CYCLE_LIMIT = 200000;

	localparam longint unsigned TURN  = 64'd1 << HB;
	localparam longint unsigned TSPAN = 3 * TURN;

	typedef struct packed {
		logic [HB-1:0]   hue;
		logic [CH_W-1:0] saturation;
		logic [CH_W-1:0] lightness;
		logic [CH_W-1:0] alpha;
	} hsla_t;

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
		logic [CH_W-1:0] alpha;
	} rgba_t;

	typedef struct packed {
		hsla_t px;
		bit    typed;
		rgba_t want;
	} row_t;

	localparam row_t PIXEL_ROWS [N_DIRECTED] = '{
		'{'{12'd0,    8'd0,   8'd0,   8'd0},   1'b1, '{8'd0,   8'd0,   8'd0,   8'd0}},
		'{'{12'd4095, 8'd0,   8'd255, 8'd255}, 1'b1, '{8'd255, 8'd255, 8'd255, 8'd255}},
		'{'{12'd1234, 8'd0,   8'd128, 8'd77},  1'b1, '{8'd128, 8'd128, 8'd128, 8'd77}},
		'{'{12'd0,    8'd255, 8'd0,   8'd255}, 1'b1, '{8'd0,   8'd0,   8'd0,   8'd255}},
		'{'{12'd2048, 8'd255, 8'd255, 8'd0},   1'b1, '{8'd255, 8'd255, 8'd255, 8'd0}},
		'{'{12'd0,    8'd255, 8'd127, 8'd128}, 1'b1, '{8'd254, 8'd0,   8'd0,   8'd128}},
		'{'{12'd0,    8'd1,   8'd127, 8'd1},   1'b0, '0},
		'{'{12'd0,    8'd255, 8'd128, 8'd2},   1'b0, '0},
		'{'{12'd0,    8'd1,   8'd128, 8'd4},   1'b0, '0},
		'{'{12'd682,  8'd200, 8'd100, 8'd8},   1'b0, '0},
		'{'{12'd683,  8'd200, 8'd100, 8'd16},  1'b0, '0},
		'{'{12'd1365, 8'd200, 8'd100, 8'd32},  1'b0, '0},
		'{'{12'd1366, 8'd200, 8'd100, 8'd64},  1'b0, '0},
		'{'{12'd2048, 8'd200, 8'd100, 8'd127}, 1'b0, '0},
		'{'{12'd2730, 8'd200, 8'd100, 8'd254}, 1'b0, '0},
		'{'{12'd2731, 8'd200, 8'd100, 8'd253}, 1'b0, '0},
		'{'{12'd2732, 8'd200, 8'd100, 8'd251}, 1'b0, '0},
		'{'{12'd4095, 8'd200, 8'd100, 8'd247}, 1'b0, '0},
		'{'{12'd3000, 8'd255, 8'd128, 8'd239}, 1'b0, '0},
		'{'{12'd2457, 8'd170, 8'd85,  8'd223}, 1'b0, '0},
		'{'{12'd2730, 8'd255, 8'd255, 8'd191}, 1'b0, '0},
		'{'{12'd1365, 8'd128, 8'd200, 8'd0},   1'b0, '0}
	};

	logic             clk;
	logic             arst_n;
	logic             s_tvalid;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata;   // hue, saturation, lightness, alpha_in
	logic             m_tvalid;
	logic             m_tready;
	logic [OUT_W-1:0] m_tdata;   // red, green, blue, alpha_out

	rgba_t rgba_q [$];
	int    accepted;
	int    mismatches;
	int    cycles;
	bit    quiet;

	hsl_to_rgb_converter i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// lo and hi are p and q scaled by 255*255, pos is the hue offset scaled by TSPAN
	function automatic logic [CH_W-1:0] ramp_level(input longint unsigned lo,
			input longint unsigned hi, input longint unsigned pos);
		longint unsigned span;
		longint unsigned acc;
		longint unsigned lvl;
		span = hi - lo;
		if (6 * pos < TSPAN)
			acc = lo * TSPAN + span * 6 * pos;
		else if (2 * pos < TSPAN)
			acc = hi * TSPAN;
		else if (3 * pos < 2 * TSPAN)
			acc = lo * TSPAN + span * (4 * TSPAN - 6 * pos);
		else
			acc = lo * TSPAN;
		lvl = acc / (255 * TSPAN);
		if (lvl > 255)
			lvl = 255;
		return lvl[CH_W-1:0];
	endfunction

	function automatic rgba_t convert_pixel(input hsla_t px);
		longint unsigned l;
		longint unsigned s;
		longint unsigned q;
		longint unsigned p;
		longint unsigned h3;
		rgba_t res;
		l = px.lightness;
		s = px.saturation;
		h3 = px.hue;
		h3 = 3 * h3;
		res.alpha = px.alpha;
		if (s == 0) begin
			res.red   = px.lightness;
			res.green = px.lightness;
			res.blue  = px.lightness;
		end else begin
			if (l <= 127)
				q = l * (255 + s);
			else
				q = l * 255 + s * 255 - l * s;
			p = 2 * l * 255 - q;
			res.red   = ramp_level(p, q, (h3 + TURN) % TSPAN);
			res.green = ramp_level(p, q, h3 % TSPAN);
			res.blue  = ramp_level(p, q, (h3 + TSPAN - TURN) % TSPAN);
		end
		return res;
	endfunction

	// enter and leave at a falling edge; valid stays high into the next pixel
	task automatic send_pixel(input hsla_t px, input rgba_t want);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		s_tdata  <= IN_W'({px.alpha, px.lightness, px.saturation, px.hue});
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		rgba_q.push_back(want);
		accepted++;
		@(negedge clk);
	endtask

	task automatic check_field(input string name, input logic [CH_W-1:0] exp_v,
			input logic [CH_W-1:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin : output_check
		rgba_t exp_px;
		if (arst_n && m_tvalid && m_tready) begin
			if (rgba_q.size() == 0) begin
				$error("unexpected output transaction: %h", m_tdata);
				mismatches++;
			end else begin
				exp_px = rgba_q.pop_front();
				check_field("red",       exp_px.red,   m_tdata[CH_W-1:0]);
				check_field("green",     exp_px.green, m_tdata[2*CH_W-1:CH_W]);
				check_field("blue",      exp_px.blue,  m_tdata[3*CH_W-1:2*CH_W]);
				check_field("alpha_out", exp_px.alpha, m_tdata[4*CH_W-1:3*CH_W]);
			end
		end
	end

	always @(posedge clk) begin : watchdog
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin : sink
		int  stall;
		bit  held_off;
		held_off = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (!held_off && accepted >= HOLD_AT) begin
				held_off = 1'b1;
				stall = HOLD_CYCLES;
			end else if (!quiet && $urandom_range(0, 5) == 0)
				stall = $urandom_range(1, 4);
			else
				stall = 0;
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			@(negedge clk);
		end
	end

	initial begin : source
		hsla_t px;
		int    pick;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		m_tready = 1'b0;
		accepted = 0;
		mismatches = 0;
		cycles   = 0;
		quiet    = 1'b0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (PIXEL_ROWS[i])
			send_pixel(PIXEL_ROWS[i].px,
				PIXEL_ROWS[i].typed ? PIXEL_ROWS[i].want : convert_pixel(PIXEL_ROWS[i].px));

		for (int n = 0; n < N_RANDOM; n++) begin
			if (n >= N_RANDOM - QUIET_TAIL)
				quiet = 1'b1;
			px.hue = HB'($urandom);
			pick = $urandom_range(0, 7);
			px.saturation = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255 : 8'($urandom);
			pick = $urandom_range(0, 15);
			case (pick)
				0: px.lightness = 8'd0;
				1: px.lightness = 8'd255;
				2: px.lightness = 8'd127;
				3: px.lightness = 8'd128;
				default: px.lightness = 8'($urandom);
			endcase
			px.alpha = 8'($urandom);
			send_pixel(px, convert_pixel(px));
		end
		s_tvalid <= 1'b0;

		while (rgba_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
